### rtl/dvbtot_pkg.sv
package dvbtot_pkg;

  localparam logic [12:0] MIN_SECTION_BYTES = 13'd14;
  localparam logic [12:0] MAX_SECTION_BYTES = 13'd1024;
  localparam logic [4:0]  MAX_DESCRIPTORS   = 5'd16;
  localparam logic [31:0] CRC_POLY          = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT          = 32'hFFFF_FFFF;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_DESC    = 2'd1,
    KIND_TRAILER = 2'd2,
    KIND_LEN_ERR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        last_of_run;
    logic [7:0]  tbl_id;
    logic [11:0] section_len_field;
    logic [39:0] utc_stamp;
    logic [11:0] loop_length;
    logic [7:0]  desc_tag;
    logic [7:0]  desc_length;
    logic [11:0] desc_offset;
    logic [4:0]  count_or_index;
    logic [31:0] crc_stored;
    logic [31:0] crc_computed;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### rtl/dvbtot_core.sv
module dvbtot_core
  import dvbtot_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic [12:0] total_length,
  output push_t       push
);

  logic [12:0]        idx_r, idx_nxt, cur_idx;
  logic [12:0]        total_r, total_nxt, cur_total;
  logic               active_r, active_nxt;
  logic [7:0]         tid_r, tid_nxt, cur_tid;
  logic [11:0]        slen_r, slen_nxt, cur_slen;
  logic [11:0]        loop_r, loop_nxt, cur_loop;
  logic [39:0]        utc_r, utc_nxt, cur_utc;
  logic [12:0]        pos_r, pos_nxt, cur_pos;
  logic signed [13:0] left_r, left_nxt, cur_left;
  logic [4:0]         cnt_r, cnt_nxt, cur_cnt;
  logic [7:0]         tag_r, tag_nxt, cur_tag;
  logic [31:0]        crc_r, crc_nxt, cur_crc;
  logic [31:0]        cw_r, cw_nxt, cur_cw;

  // section state as seen by this word: cleared on a first word
  always_comb begin
    if (first_byte) begin
      cur_idx   = '0;
      cur_total = total_length;
      cur_tid   = '0;
      cur_slen  = '0;
      cur_loop  = '0;
      cur_utc   = '0;
      cur_pos   = '0;
      cur_left  = '0;
      cur_cnt   = '0;
      cur_tag   = '0;
      cur_crc   = CRC_INIT;
      cur_cw    = '0;
    end else begin
      cur_idx   = idx_r;
      cur_total = total_r;
      cur_tid   = tid_r;
      cur_slen  = slen_r;
      cur_loop  = loop_r;
      cur_utc   = utc_r;
      cur_pos   = pos_r;
      cur_left  = left_r;
      cur_cnt   = cnt_r;
      cur_tag   = tag_r;
      cur_crc   = crc_r;
      cur_cw    = cw_r;
    end
  end

  always_comb begin
    logic [13:0] i14;
    logic [13:0] off;
    logic [13:0] cp;
    logic [1:0]  sel;
    logic [11:0] hdr_loop;
    logic        have_a;
    logic        have_t;
    res_t        ra;
    res_t        rt;

    i14      = {1'b0, cur_idx};
    off      = {1'b0, cur_pos};
    cp       = 14'd10 + {2'b00, cur_loop};
    sel      = 2'(i14 - cp);
    hdr_loop = {cur_loop[11:8], data_byte};
    have_a   = 1'b0;
    have_t   = 1'b0;
    ra       = '0;
    rt       = '0;

    idx_nxt    = idx_r;
    total_nxt  = total_r;
    active_nxt = active_r;
    tid_nxt    = tid_r;
    slen_nxt   = slen_r;
    loop_nxt   = loop_r;
    utc_nxt    = utc_r;
    pos_nxt    = pos_r;
    left_nxt   = left_r;
    cnt_nxt    = cnt_r;
    tag_nxt    = tag_r;
    crc_nxt    = crc_r;
    cw_nxt     = cw_r;

    if (accept && (first_byte || active_r)) begin
      idx_nxt    = cur_idx;
      total_nxt  = cur_total;
      tid_nxt    = cur_tid;
      slen_nxt   = cur_slen;
      loop_nxt   = cur_loop;
      utc_nxt    = cur_utc;
      pos_nxt    = cur_pos;
      left_nxt   = cur_left;
      cnt_nxt    = cur_cnt;
      tag_nxt    = cur_tag;
      crc_nxt    = cur_crc;
      cw_nxt     = cur_cw;
      active_nxt = 1'b1;

      if (first_byte &&
          (total_length < MIN_SECTION_BYTES || total_length > MAX_SECTION_BYTES)) begin
        active_nxt     = 1'b0;
        have_a         = 1'b1;
        ra.kind        = KIND_LEN_ERR;
      end else begin
        if (i14 + 14'd4 < {1'b0, cur_total}) begin
          crc_nxt = crc_byte(cur_crc, data_byte);
        end

        if (cur_idx == 13'd0) begin
          tid_nxt = data_byte;
        end else if (cur_idx == 13'd1) begin
          slen_nxt[11:8] = data_byte[3:0];
        end else if (cur_idx == 13'd2) begin
          slen_nxt[7:0] = data_byte;
        end else if (cur_idx >= 13'd3 && cur_idx <= 13'd7) begin
          utc_nxt = {cur_utc[31:0], data_byte};
        end else if (cur_idx == 13'd8) begin
          loop_nxt[11:8] = data_byte[3:0];
        end else if (cur_idx == 13'd9) begin
          loop_nxt             = hdr_loop;
          left_nxt             = $signed({2'b00, hdr_loop});
          pos_nxt              = 13'd10;
          have_a               = 1'b1;
          ra.kind              = KIND_HEADER;
          ra.tbl_id            = cur_tid;
          ra.section_len_field = cur_slen;
          ra.utc_stamp         = cur_utc;
          ra.loop_length       = hdr_loop;
        end else begin
          if (i14 == off) begin
            tag_nxt = data_byte;
          end else if (i14 == off + 14'd1 && cur_left >= 14'sd2 &&
                       cur_cnt < MAX_DESCRIPTORS) begin
            have_a            = 1'b1;
            ra.kind           = KIND_DESC;
            ra.desc_tag       = cur_tag;
            ra.desc_length    = data_byte;
            ra.desc_offset    = cur_pos[11:0];
            ra.count_or_index = cur_cnt;
            cnt_nxt           = cur_cnt + 5'd1;
            left_nxt          = cur_left - $signed({6'd0, data_byte}) - 14'sd2;
            pos_nxt           = 13'(off + {6'd0, data_byte} + 14'd2);
          end
          if (i14 >= cp && i14 < cp + 14'd4) begin
            case (sel)
              2'd0:    cw_nxt[31:24] = cur_cw[31:24] | data_byte;
              2'd1:    cw_nxt[23:16] = cur_cw[23:16] | data_byte;
              2'd2:    cw_nxt[15:8]  = cur_cw[15:8]  | data_byte;
              default: cw_nxt[7:0]   = cur_cw[7:0]   | data_byte;
            endcase
          end
        end

        if (i14 + 14'd1 >= {1'b0, cur_total}) begin
          have_t            = 1'b1;
          rt.kind           = KIND_TRAILER;
          rt.last_of_run    = 1'b1;
          rt.count_or_index = cnt_nxt;
          rt.crc_stored     = cw_nxt;
          rt.crc_computed   = crc_nxt;
          active_nxt        = 1'b0;
        end else begin
          idx_nxt = 13'(i14 + 14'd1);
        end
      end
    end

    ra.last_of_run = have_a && !have_t;
    push = '0;
    push.n = {1'b0, have_a} + {1'b0, have_t};
    if (have_a) begin
      push.r0 = ra;
      push.r1 = rt;
    end else begin
      push.r0 = rt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      total_r  <= '0;
      active_r <= 1'b0;
      tid_r    <= '0;
      slen_r   <= '0;
      loop_r   <= '0;
      utc_r    <= '0;
      pos_r    <= '0;
      left_r   <= '0;
      cnt_r    <= '0;
      tag_r    <= '0;
      crc_r    <= CRC_INIT;
      cw_r     <= '0;
    end else begin
      idx_r    <= idx_nxt;
      total_r  <= total_nxt;
      active_r <= active_nxt;
      tid_r    <= tid_nxt;
      slen_r   <= slen_nxt;
      loop_r   <= loop_nxt;
      utc_r    <= utc_nxt;
      pos_r    <= pos_nxt;
      left_r   <= left_nxt;
      cnt_r    <= cnt_nxt;
      tag_r    <= tag_nxt;
      crc_r    <= crc_nxt;
      cw_r     <= cw_nxt;
    end
  end

endmodule

### rtl/dvbtot_fifo.sv
module dvbtot_fifo
  import dvbtot_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output logic  can_take,
  output logic  head_valid,
  output res_t  head
);

  res_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]    count_r, count_nxt;
  logic                pop_fire;

  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign pop_fire   = pop && head_valid;
  // room for the two results one word can cause
  assign can_take   = (count_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.n);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop_fire);
    count_nxt  = count_r + (FIFO_AW+1)'(push.n) - (FIFO_AW+1)'(pop_fire);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + FIFO_AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/dvb_tot_section_parser.sv
// channel   dir  handshake             payload
// in_       in   in_tvalid/in_tready   tdata: data_byte, total_length; tuser: first_byte
// out_      out  out_tvalid/out_tready tdata: result fields; tuser: kind; tlast: last_of_run
//
// one input word per cycle while in_tready is high; the section state and the crc byte step
// sit between the input port and a four-entry result queue, into which results are registered
// a word causes up to two results (descriptor plus trailer); the queue drains one per
// cycle while out_tready is high, and in_tready drops while fewer than two entries are free
// rst_n is synchronous: parser idle, crc preset to all ones, queue empty
// out_tready low stalls only the queue; input is taken until under two entries are free
module dvb_tot_section_parser
  import dvbtot_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // data_byte, total_length
  input  logic [0:0]   in_tuser,   // first_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [175:0] out_tdata,  // tbl_id, section_len_field, utc_stamp, loop_length,
                                   // desc_tag, desc_length, desc_offset, count_or_index,
                                   // crc_stored, crc_computed
  output logic [1:0]   out_tuser,  // kind
  output logic         out_tlast
);

  push_t push;
  res_t  head;
  logic  accept;

  assign accept = in_tvalid && in_tready;

  dvbtot_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_tdata[7:0]),
    .first_byte   (in_tuser[0]),
    .total_length (in_tdata[20:8]),
    .push         (push)
  );

  dvbtot_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_tready),
    .can_take   (in_tready),
    .head_valid (out_tvalid),
    .head       (head)
  );

  assign out_tuser = head.kind;
  assign out_tlast = head.last_of_run;
  assign out_tdata = {7'd0, head.crc_computed, head.crc_stored, head.count_or_index,
                      head.desc_offset, head.desc_length, head.desc_tag, head.loop_length,
                      head.utc_stamp, head.section_len_field, head.tbl_id};

`ifndef ASSERT_OFF
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd3)
    else $error("more than two results from one word");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> accept)
    else $error("result pushed without an accepted word");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_LEN_ERR) |-> out_tlast)
    else $error("length error result not last");

  a_trailer_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_TRAILER) |-> out_tlast)
    else $error("trailer result not last");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import dvbtot_pkg::*;

  localparam logic [31:0] MPEG_CRC_POLY = 32'h04C1_1DB7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 220;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    kind_t       kind;
    logic        last;
    logic [7:0]  tbl_id;
    logic [11:0] sec_len;
    logic [39:0] utc;
    logic [11:0] loop_len;
    logic [7:0]  tag;
    logic [7:0]  dlen;
    logic [11:0] offset;
    logic [4:0]  count;
    logic [31:0] crc_stored;
    logic [31:0] crc_calc;
  } tot_result_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [23:0]  in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [175:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  dvb_tot_section_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // section parser shadow state
  logic        p_active;
  int          p_index;
  int          p_total;
  logic [7:0]  p_tid;
  logic [11:0] p_slen;
  logic [11:0] p_loop;
  logic [39:0] p_utc;
  int          p_desc_pos;
  int          p_loop_left;
  int          p_ndesc;
  logic [7:0]  p_tag;
  logic [31:0] p_crc;
  logic [31:0] p_crc_word;

  tot_result_t tot_results_due[$];
  int          errors = 0;
  int          words_sent = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  int          desc_plan[$];

  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] crc32_mpeg_step(logic [31:0] acc, logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = acc[31] ^ b[k];
      acc = {acc[30:0], 1'b0};
      if (fb) acc = acc ^ MPEG_CRC_POLY;
    end
    return acc;
  endfunction

  task automatic clear_section_state();
    p_index = 0;
    p_tid = '0;
    p_slen = '0;
    p_loop = '0;
    p_utc = '0;
    p_desc_pos = 0;
    p_loop_left = 0;
    p_ndesc = 0;
    p_tag = '0;
    p_crc = '1;
    p_crc_word = '0;
  endtask

  task automatic tot_parse_byte(input logic [7:0] d, input logic f, input logic [12:0] tl);
    tot_result_t r[2];
    int n;
    int i;
    int cp;
    n = 0;
    r[0] = '0;
    r[1] = '0;
    if (f) begin
      clear_section_state();
      p_total = tl;
      if (tl < MIN_SECTION_BYTES || tl > MAX_SECTION_BYTES) begin
        p_active = 1'b0;
        r[0].kind = KIND_LEN_ERR;
        r[0].last = 1'b1;
        tot_results_due.push_back(r[0]);
        return;
      end
      p_active = 1'b1;
    end else if (!p_active) begin
      return;
    end
    i = p_index;
    if (i + 4 < p_total) p_crc = crc32_mpeg_step(p_crc, d);
    if (i == 0) begin
      p_tid = d;
    end else if (i == 1) begin
      p_slen[11:8] = d[3:0];
    end else if (i == 2) begin
      p_slen[7:0] = d;
    end else if (i >= 3 && i <= 7) begin
      p_utc = {p_utc[31:0], d};
    end else if (i == 8) begin
      p_loop[11:8] = d[3:0];
    end else if (i == 9) begin
      p_loop[7:0] = d;
      p_loop_left = p_loop;
      p_desc_pos = 10;
      r[n].kind = KIND_HEADER;
      r[n].tbl_id = p_tid;
      r[n].sec_len = p_slen;
      r[n].utc = p_utc;
      r[n].loop_len = p_loop;
      n++;
    end else begin
      if (i == p_desc_pos) begin
        p_tag = d;
      end else if (i == p_desc_pos + 1 && p_loop_left >= 2 && p_ndesc < MAX_DESCRIPTORS) begin
        r[n].kind = KIND_DESC;
        r[n].tag = p_tag;
        r[n].dlen = d;
        r[n].offset = p_desc_pos[11:0];
        r[n].count = p_ndesc[4:0];
        n++;
        p_ndesc++;
        p_loop_left = p_loop_left - (int'(d) + 2);
        p_desc_pos = p_desc_pos + int'(d) + 2;
      end
      cp = 10 + int'(p_loop);
      if (i >= cp && i < cp + 4) p_crc_word = p_crc_word | (32'(d) << (8 * (3 - (i - cp))));
    end
    if (i + 1 >= p_total) begin
      r[n].kind = KIND_TRAILER;
      r[n].count = p_ndesc[4:0];
      r[n].crc_stored = p_crc_word;
      r[n].crc_calc = p_crc;
      n++;
      p_active = 1'b0;
    end else begin
      p_index = i + 1;
    end
    if (n > 0) r[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) tot_results_due.push_back(r[k]);
  endtask

  task automatic send_word(input logic [7:0] d, input logic f, input logic [12:0] tl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, tl, d};
    in_tuser <= f;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    tot_parse_byte(d, f, tl);
  endtask

  task automatic send_noise(input int count);
    for (int k = 0; k < count; k++) send_word(8'($urandom), 1'b0, 13'($urandom_range(0, 4098)));
  endtask

  // sends the first count bytes of a section; later bytes carry a junk total_length
  task automatic send_section(input byte_q_t sec, input int total, input int count);
    for (int k = 0; k < count; k++) begin
      if (k == 0) send_word(sec[k], 1'b1, total[12:0]);
      else send_word(sec[k], 1'b0, 13'($urandom_range(0, 4098)));
    end
  endtask

  // section built from desc_plan; loop_field < 0 keeps the loop length consistent
  task automatic build_tot(input logic [7:0] tid, input int loop_field, input bit good_crc,
                           output byte_q_t sec, output int total);
    int loop;
    logic [11:0] lf;
    logic [11:0] slen;
    logic [31:0] crc;
    loop = 0;
    foreach (desc_plan[k]) loop += desc_plan[k] + 2;
    total = 14 + loop;
    lf = (loop_field < 0) ? loop[11:0] : loop_field[11:0];
    slen = 12'(total - 3);
    sec = {};
    sec.push_back(tid);
    sec.push_back({4'($urandom_range(0, 15)), slen[11:8]});
    sec.push_back(slen[7:0]);
    repeat (5) sec.push_back(8'($urandom));
    sec.push_back({4'($urandom_range(0, 15)), lf[11:8]});
    sec.push_back(lf[7:0]);
    foreach (desc_plan[k]) begin
      sec.push_back(8'($urandom));
      sec.push_back(8'(desc_plan[k]));
      repeat (desc_plan[k]) sec.push_back(8'($urandom));
    end
    crc = '1;
    foreach (sec[k]) crc = crc32_mpeg_step(crc, sec[k]);
    if (!good_crc) crc = $urandom;
    for (int k = 3; k >= 0; k--) sec.push_back(crc[8*k +: 8]);
  endtask

  task automatic test_idle_words();
    send_noise(3);
  endtask

  task automatic test_length_errors();
    int bad_len[6] = '{0, 13, 1025, 4095, 4096, 4098};
    foreach (bad_len[k]) begin
      send_word(8'($urandom), 1'b1, bad_len[k][12:0]);
      send_noise(1);
    end
  endtask

  task automatic test_min_section();
    byte_q_t sec;
    int total;
    desc_plan = {};
    build_tot(8'h73, -1, 1'b1, sec, total);
    send_section(sec, total, total);
  endtask

  // long section cut short once both descriptor results are out
  task automatic test_desc_extremes();
    byte_q_t sec;
    int total;
    desc_plan = {0, 255};
    build_tot(8'hff, -1, 1'b1, sec, total);
    send_section(sec, total, 20);
    desc_plan = {1};
    build_tot(8'h00, -1, 1'b0, sec, total);
    send_section(sec, total, total);
  endtask

  task automatic test_restart();
    byte_q_t sec;
    int total;
    desc_plan = {4};
    build_tot(8'h73, -1, 1'b1, sec, total);
    send_section(sec, total, 12);
    desc_plan = {1, 2};
    build_tot(8'h73, -1, 1'b1, sec, total);
    send_section(sec, total, total);
  endtask

  // loop length points far past the end: crc bytes read as zero
  task automatic test_loop_past_end();
    byte_q_t sec;
    int total;
    desc_plan = {5};
    build_tot(8'h73, 300, 1'b1, sec, total);
    send_section(sec, total, total);
  endtask

  task automatic test_loop_overrun();
    byte_q_t sec;
    int total;
    desc_plan = {10};
    build_tot(8'h73, 3, 1'b1, sec, total);
    send_section(sec, total, total);
  endtask

  task automatic test_desc_limit();
    byte_q_t sec;
    int total;
    desc_plan = {};
    repeat (18) desc_plan.push_back(0);
    build_tot(8'h73, -1, 1'b1, sec, total);
    send_section(sec, total, total);
  endtask

  // largest allowed length, abandoned after the header and first descriptor
  task automatic test_full_size();
    byte_q_t sec;
    int total;
    desc_plan = {255, 255, 255, 237};
    build_tot(8'h73, 4095, 1'b1, sec, total);
    send_section(sec, total, 40);
  endtask

  task automatic test_random_sections();
    byte_q_t sec;
    int total;
    int budget;
    int sel;
    int ndesc;
    budget = 0;
    while (budget < RANDOM_WORDS) begin
      sel = $urandom_range(0, 99);
      desc_plan = {};
      ndesc = $urandom_range(0, 5);
      for (int k = 0; k < ndesc; k++) begin
        if (k == 0 && $urandom_range(0, 9) == 0) desc_plan.push_back($urandom_range(13, 255));
        else desc_plan.push_back($urandom_range(0, 12));
      end
      if (sel < 65) begin
        build_tot(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h73, -1,
                  $urandom_range(0, 3) != 0, sec, total);
        send_section(sec, total, total);
        budget += total;
      end else if (sel < 80) begin
        build_tot(8'($urandom),
                  ($urandom_range(0, 1) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 4095),
                  $urandom_range(0, 1) == 1, sec, total);
        send_section(sec, total, total);
        budget += total;
      end else if (sel < 88) begin
        send_word(8'($urandom), 1'b1, ($urandom_range(0, 1) == 0) ?
                  13'($urandom_range(0, 13)) : 13'($urandom_range(1025, 4098)));
        send_noise($urandom_range(0, 3));
        budget += 1;
      end else if (sel < 95) begin
        build_tot(8'h73, -1, 1'b1, sec, total);
        sel = $urandom_range(1, total - 1);
        send_section(sec, total, sel);
        budget += sel;
      end else begin
        send_noise($urandom_range(1, 4));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    tot_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (tot_results_due.size() == 0) begin
        $error("unexpected result word, kind %0d", out_tuser);
        errors++;
      end else begin
        want = tot_results_due.pop_front();
        check_field("kind", want.kind, out_tuser);
        check_field("last_of_run", want.last, out_tlast);
        check_field("tbl_id", want.tbl_id, out_tdata[7:0]);
        check_field("section_len_field", want.sec_len, out_tdata[19:8]);
        check_field("utc_stamp", want.utc, out_tdata[59:20]);
        check_field("loop_length", want.loop_len, out_tdata[71:60]);
        check_field("desc_tag", want.tag, out_tdata[79:72]);
        check_field("desc_length", want.dlen, out_tdata[87:80]);
        check_field("desc_offset", want.offset, out_tdata[99:88]);
        check_field("count_or_index", want.count, out_tdata[104:100]);
        check_field("crc_stored", want.crc_stored, out_tdata[136:105]);
        check_field("crc_computed", want.crc_calc, out_tdata[168:137]);
      end
    end
  end

  // receiver stall pattern: always ready, random, mostly stalled, periodic
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= stall_phase[2];
    endcase
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    clear_section_state();
    p_active = 1'b0;
    p_total = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_words();
    test_length_errors();
    test_min_section();
    test_desc_extremes();
    test_restart();
    test_loop_past_end();
    test_loop_overrun();
    test_desc_limit();
    test_full_size();
    test_random_sections();
    in_tvalid <= 1'b0;
    while (tot_results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### dvb_tot_section_parser.f
rtl/dvbtot_pkg.sv
rtl/dvbtot_core.sv
rtl/dvbtot_fifo.sv
rtl/dvb_tot_section_parser.sv
bench/tb.sv
